/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and types of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int ADDR_W      = 48;
   localparam int BSIZE_W     = 21;
   localparam int ALIGN_W     = 5;
   localparam int BLK_W       = 11;
   localparam int SIZE_W      = 32;
   localparam int PROD_W      = BLK_W + SIZE_W;
   localparam int WORD_BITS   = 32;
   localparam int WORD_IDX_W  = 5;
   localparam int VISIT_W     = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int STATUS_W    = 2;
   localparam int QDEPTH      = 2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BSIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 3'd3;

   // classified request as it waits between front and back
   typedef struct packed {
      logic              func;
      logic              below;
      logic [ADDR_W-1:0] diff;
   } req_item_type;

   // effective pool geometry
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      logic [BLK_W-1:0]  count;
   } pool_cfg_type;

   // index of lowest set bit
   function automatic logic [WORD_IDX_W-1:0] ffs32(input logic [WORD_BITS-1:0] v);
      logic [WORD_IDX_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = WORD_IDX_W'(i);
      end
      return r;
   endfunction

endpackage

/* rtl/bba_ram.sv */
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bba_div.sv */
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in BLK_W bits.
// ----------------------------------------------------------------------------
module bba_div
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [BLK_W-1:0]  quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [3:0]        k_ff, k_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [BLK_W-1:0]  q_ff, q_in;
   logic [PROD_W-1:0] trial;

   assign trial = PROD_W'(divisor) << k_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = 4'(BLK_W - 1);
         rem_in  = dividend;
         q_in    = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in     = rem_ff - trial;
            q_in[k_ff] = 1'b1;
         end
         if (k_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      k_ff   <= k_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

/* rtl/bba_front.sv */
// ----------------------------------------------------------------------------
// bba_front
// Accepts requests, classifies them against the base address and queues
// them for the execution side.
// ----------------------------------------------------------------------------
module bba_front
   import bba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              func,
   input  logic [ADDR_W-1:0] address,
   input  logic [ADDR_W-1:0] base,
   output logic              q_full,
   output logic              q_valid,
   output req_item_type      q_item,
   input  logic              q_pop
);

   req_item_type     entry_ff [QDEPTH];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   req_item_type     new_item;

   always_comb begin
      new_item.func  = func;
      new_item.below = (address < base);
      new_item.diff  = address - base;
   end

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) wptr_in = ~wptr_ff;
      if (q_pop) rptr_in = ~rptr_ff;
      if (push && !q_pop) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) entry_ff[wptr_ff] <= new_item;
   end

   assign q_full  = (cnt_ff == 2'(QDEPTH));
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = entry_ff[rptr_ff];

endmodule

/* rtl/bba_back.sv */
// ----------------------------------------------------------------------------
// bba_back
// Executes requests: next-fit map search a word per cycle, address
// multiply, range check and block-number division for frees, map clearing.
// ----------------------------------------------------------------------------
module bba_back
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                init,
   input  pool_cfg_type        cfg,
   input  logic                q_valid,
   input  req_item_type        q_item,
   output logic                q_pop,
   output logic                clearing,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_block_address,
   output logic [BLK_W-1:0]    rsp_free_count
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_AMUL = 4'd3;
   localparam logic [3:0] S_AADR = 4'd4;
   localparam logic [3:0] S_FMUL = 4'd5;
   localparam logic [3:0] S_FCMP = 4'd6;
   localparam logic [3:0] S_FDIV = 4'd7;
   localparam logic [3:0] S_FRD  = 4'd8;
   localparam logic [3:0] S_FCHK = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [AW-1:0]         cur_w_ff, cur_w_in;
   logic [VISIT_W-1:0]    visit_ff, visit_in;
   logic [WORD_IDX_W-1:0] slo_ff, slo_in;
   logic [BLK_W-1:0]      next_ff, next_in;
   logic [BLK_W-1:0]      free_ff, free_in;
   req_item_type          item_ff, item_in;
   logic [BLK_W-1:0]      hit_ff, hit_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [STATUS_W-1:0]   st_ff, st_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic                  rv_ff, rv_in;
   logic [STATUS_W-1:0]   rst_ff, rst_in;
   logic [ADDR_W-1:0]     raddr_ff, raddr_in;
   logic [BLK_W-1:0]      rfree_ff, rfree_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;
   logic                  div_start, div_done;
   logic [BLK_W-1:0]      div_quot;

   logic [VISIT_W-1:0]    nwords;
   logic [BLK_W-1:0]      start_idx, base_idx, rem_blk, hit_idx;
   logic [WORD_BITS-1:0]  cnt_mask, lo_mask, win_mask, avail;
   logic [WORD_IDX_W-1:0] ffs;
   logic [AW-1:0]         nxt_w, blk_w;
   logic [BLK_W-1:0]      mul_a;

   bba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (PROD_W'(item_ff.diff)),
      .divisor  (cfg.size),
      .done     (div_done),
      .quot     (div_quot)
   );

   // search window: first visit of the start word takes bits at or above the
   // start, the wrap-around visit takes bits below it
   always_comb begin
      nwords    = VISIT_W'((12'(cfg.count) + 12'd31) >> WORD_IDX_W);
      start_idx = (next_ff >= cfg.count) ? '0 : next_ff;
      base_idx  = BLK_W'({cur_w_ff, {WORD_IDX_W{1'b0}}});
      rem_blk   = cfg.count - base_idx;
      cnt_mask  = (rem_blk >= BLK_W'(WORD_BITS)) ? '1
                : ((32'd1 << rem_blk[WORD_IDX_W-1:0]) - 32'd1);
      lo_mask   = (32'd1 << slo_ff) - 32'd1;
      if (visit_ff == '0) win_mask = ~lo_mask;
      else if (visit_ff == nwords) win_mask = lo_mask;
      else win_mask = '1;
      avail     = ~ram_rdata & cnt_mask & win_mask;
      ffs       = ffs32(avail);
      hit_idx   = BLK_W'({cur_w_ff, ffs});
      nxt_w     = (VISIT_W'(cur_w_ff) + VISIT_W'(1) == nwords) ? '0 : cur_w_ff + AW'(1);
      blk_w     = AW'(hit_ff[BLK_W-1:WORD_IDX_W]);
      mul_a     = (state_ff == S_AMUL) ? hit_ff : cfg.count;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_w_in  = cur_w_ff;
      visit_in  = visit_ff;
      slo_in    = slo_ff;
      next_in   = next_ff;
      free_in   = free_ff;
      item_in   = item_ff;
      hit_in    = hit_ff;
      prod_in   = prod_ff;
      st_in     = st_ff;
      addr_in   = addr_ff;
      rv_in     = (rv_ff && rsp_pop) ? 1'b0 : rv_ff;
      rst_in    = rst_ff;
      raddr_in  = raddr_ff;
      rfree_in  = rfree_ff;
      ram_we    = 1'b0;
      ram_waddr = cur_w_ff;
      ram_wdata = '0;
      ram_raddr = cur_w_ff;
      div_start = 1'b0;
      q_pop     = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            if (clr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
               next_in  = '0;
               free_in  = cfg.count;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               addr_in = '0;
               st_in   = ST_OK;
               if (q_item.func == FUNC_ALLOC) begin
                  if (cfg.count == '0) begin
                     st_in    = ST_NOFREE;
                     state_in = S_DONE;
                  end else begin
                     ram_raddr = AW'(start_idx[BLK_W-1:WORD_IDX_W]);
                     cur_w_in  = AW'(start_idx[BLK_W-1:WORD_IDX_W]);
                     slo_in    = start_idx[WORD_IDX_W-1:0];
                     visit_in  = '0;
                     state_in  = S_SCAN;
                  end
               end else if (q_item.below || cfg.count == '0) begin
                  st_in    = ST_RANGE;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FMUL;
               end
            end
         end
         S_SCAN: begin
            if (avail != '0) begin
               ram_we    = 1'b1;
               ram_waddr = cur_w_ff;
               ram_wdata = ram_rdata | (32'd1 << ffs);
               hit_in    = hit_idx;
               next_in   = hit_idx + BLK_W'(1);
               if (free_ff != '0) free_in = free_ff - BLK_W'(1);
               state_in  = S_AMUL;
            end else if (visit_ff == nwords) begin
               st_in    = ST_NOFREE;
               state_in = S_DONE;
            end else begin
               // next word read goes out while this one is checked
               ram_raddr = nxt_w;
               cur_w_in  = nxt_w;
               visit_in  = visit_ff + VISIT_W'(1);
            end
         end
         S_AMUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(cfg.size);
            state_in = S_AADR;
         end
         S_AADR: begin
            addr_in  = cfg.base + ADDR_W'(prod_ff);
            state_in = S_DONE;
         end
         S_FMUL: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(cfg.size);
            state_in = S_FCMP;
         end
         S_FCMP: begin
            // offset at or past count * size is beyond the pool
            if (item_ff.diff >= ADDR_W'(prod_ff)) begin
               st_in    = ST_RANGE;
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_done) begin
               hit_in   = div_quot;
               state_in = S_FRD;
            end
         end
         S_FRD: begin
            ram_raddr = blk_w;
            state_in  = S_FCHK;
         end
         S_FCHK: begin
            if (!ram_rdata[hit_ff[WORD_IDX_W-1:0]]) begin
               st_in = ST_ALREADY;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = blk_w;
               ram_wdata = ram_rdata & ~(32'd1 << hit_ff[WORD_IDX_W-1:0]);
               if (free_ff < cfg.count) free_in = free_ff + BLK_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rv_ff || rsp_pop) begin
               rv_in    = 1'b1;
               rst_in   = st_ff;
               raddr_in = addr_ff;
               rfree_in = free_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
            clr_in   = '0;
         end
      endcase

      if (init) begin
         state_in = S_CLR;
         clr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         next_ff  <= '0;
         free_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         next_ff  <= next_in;
         free_ff  <= free_in;
         rv_ff    <= rv_in;
      end
      cur_w_ff <= cur_w_in;
      visit_ff <= visit_in;
      slo_ff   <= slo_in;
      item_ff  <= item_in;
      hit_ff   <= hit_in;
      prod_ff  <= prod_in;
      st_ff    <= st_in;
      addr_ff  <= addr_in;
      rst_ff   <= rst_in;
      raddr_ff <= raddr_in;
      rfree_ff <= rfree_in;
   end

   assign clearing          = (state_ff == S_CLR);
   assign rsp_empty         = !rv_ff;
   assign rsp_status        = rst_ff;
   assign rsp_block_address = raddr_ff;
   assign rsp_free_count    = rfree_ff;

   a_addr_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rst_ff != ST_OK) |-> (raddr_ff == '0))
      else $error("nonzero block address on failed request");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLR) |-> (free_ff <= cfg.count))
      else $error("free count above block count");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      init |=> (state_ff == S_CLR))
      else $error("pool init did not start map clearing");

   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == S_IDLE && q_valid))
      else $error("request taken outside idle");

endmodule

/* rtl/bitmap_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// Next-fit fixed-size block allocator over a one-bit-per-block usage map.
// ----------------------------------------------------------------------------
// Requests are handled one at a time by the execution side while up to two
// more wait in the request queue and one response waits in the output
// register. An allocate's map search reads one 32-bit map word per cycle
// from the map RAM, then a multiply and an add form the address. A free
// takes a multiply for the range limit, an 11-step restoring divider for
// the block number, and a read-modify-write of one map word. After reset and
// after every write to the base, size, alignment or count register the map
// RAM is cleared one word per cycle; req_full stays high while it clears.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_func,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]    rsp_block_address,
   output logic [BLK_W-1:0]     rsp_free_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   logic [ADDR_W-1:0]  base_ff;
   logic [BSIZE_W-1:0] bsize_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [BLK_W-1:0]   count_ff;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  unit, rounded;
   logic [BLK_W-1:0]   eff_count;
   logic               csr_wr, init;
   logic               q_full, q_valid, q_pop, clearing;
   req_item_type       q_item;
   pool_cfg_type       cfg;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign init      = csr_wr && (csr_index == CSR_BASE || csr_index == CSR_BSIZE ||
                                 csr_index == CSR_ALIGN || csr_index == CSR_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         bsize_ff <= BSIZE_W'(64);
         align_ff <= '0;
         count_ff <= BLK_W'(1024);
      end else if (csr_wr) begin
         case (csr_index)
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_BSIZE: bsize_ff <= csr_wdata[BSIZE_W-1:0];
            CSR_ALIGN: align_ff <= csr_wdata[ALIGN_W-1:0];
            CSR_COUNT: count_ff <= csr_wdata[BLK_W-1:0];
            default: ;
         endcase
      end
      size_ff <= size_in;
   end

   // size rounded up to the alignment; zero becomes one alignment unit
   always_comb begin
      unit      = 32'd1 << align_ff;
      rounded   = (SIZE_W'(bsize_ff) + unit - 32'd1) & ~(unit - 32'd1);
      size_in   = (rounded == '0) ? unit : rounded;
      eff_count = (32'(count_ff) > 32'(MAX_BLOCKS)) ? BLK_W'(MAX_BLOCKS) : count_ff;
      cfg.base  = base_ff;
      cfg.size  = size_ff;
      cfg.count = eff_count;
   end

   assign req_full = q_full || clearing || csr_valid;

   bba_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push && !req_full),
      .func    (req_func),
      .address (req_address),
      .base    (base_ff),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   bba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .init              (init),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .clearing          (clearing),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_free_count    (rsp_free_count)
   );

endmodule
